/* design/ppsc_pkg.sv */
// ----------------------------------------------------------------------------
// ppsc_pkg - shared types for the preemptive priority scheduler
// Task entry layout, sequencer and cell phase codes, heap ordering function.
// ----------------------------------------------------------------------------
package ppsc_pkg;

   // default number of queue slots
   localparam int QUEUE_DEPTH_DEF = 16;

   // one queued task, 64 bits
   typedef struct packed {
      logic [15:0] start_tick;
      logic [15:0] arrival_tick;
      logic [7:0]  remaining;
      logic [7:0]  prio;
      logic [7:0]  burst;
      logic [7:0]  id;
   } task_entry_type;

   localparam int ENTRY_W = $bits(task_entry_type);

   // top level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_WALK
   } sched_state_type;

   // operation carried down the chain of level cells
   // insert: new task still looking for its slot
   // shift:  displaced task, every lower slot on the path moves down one
   // sift:   moved last task pushed below larger children
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_SHIFT,
      OP_SIFT
   } heap_op_type;

   // a cell reads its RAM in one phase and decides in the next
   typedef enum logic {
      PH_READ,
      PH_EXEC
   } cell_phase_type;

   // true when a must be served before b: higher priority, then lower id
   function automatic logic ahead(task_entry_type a, task_entry_type b);
      logic res;
      if (a.prio != b.prio) begin
         res = (a.prio > b.prio);
      end else begin
         res = (a.id < b.id);
      end
      return res;
   endfunction

endpackage

/* design/ppsc_ram.sv */
// ----------------------------------------------------------------------------
// ppsc_ram - generic RAM, one write port, two registered read ports
// Read returns the contents before a write to the same address.
// ----------------------------------------------------------------------------
module ppsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* design/ppsc_cell.sv */
// ----------------------------------------------------------------------------
// ppsc_cell - one level of the heap
// Holds the slots of one heap level in its own RAM. A token walks down the
// chain: insert moves the new task along the path to its slot, displacing
// lower keys; sift-down pushes the moved last task below larger children.
// ----------------------------------------------------------------------------
module ppsc_cell #(
   parameter int DEPTH = ppsc_pkg::QUEUE_DEPTH_DEF,
   parameter int LEVEL = 0
) (
   clock, reset, tok_prev, tok_next, kreq_prev, kreq_next,
   kid_in, rd_a, rd_b, ctrl, done
);
   import ppsc_pkg::*;

   localparam int OW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int NL    = CW;
   localparam int LW    = $clog2(NL);
   localparam int IW    = CW + 1;
   localparam int LVSZ  = 2 ** LEVEL;
   localparam int SIZE  = (LVSZ < DEPTH - LVSZ + 1) ? LVSZ : DEPTH - LVSZ + 1;
   localparam int AW    = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int LBASE = 2 ** (LEVEL + 1) - 1;

   typedef struct packed {
      logic           valid;
      heap_op_type    op;
      task_entry_type entry;
      logic [OW-1:0]  off;
      logic [CW-1:0]  cnt;
      logic [CW-1:0]  path;
      logic [LW-1:0]  dest_lvl;
   } token_type;

   typedef struct packed {
      logic          valid;
      logic [OW-1:0] off;
   } child_req_type;

   typedef struct packed {
      task_entry_type a;
      task_entry_type b;
   } child_data_type;

   typedef struct packed {
      logic [OW-1:0]  rd_off;
      logic           root_we;
      task_entry_type root_data;
   } ctrl_type;

   input  logic           clock;
   input  logic           reset;
   input  token_type      tok_prev;
   output token_type      tok_next;
   input  child_req_type  kreq_prev;
   output child_req_type  kreq_next;
   input  child_data_type kid_in;
   output task_entry_type rd_a;
   output task_entry_type rd_b;
   input  ctrl_type       ctrl;
   output logic           done;

   token_type      tok_ff, tok_in;
   cell_phase_type phase_ff, phase_in;

   logic               exec;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   task_entry_type     wr_data;
   logic [AW-1:0]      addr_a, addr_b;
   logic [ENTRY_W-1:0] ram_a, ram_b;
   token_type          fwd;
   logic [IW-1:0]      lidx, ridx, cnt_ext;
   logic               pick_l, pick_r;
   task_entry_type     best_e;

   assign exec = tok_ff.valid && (phase_ff == PH_EXEC);

   // read addresses: own slot for insert and shift, children for the level above, else port b reads the last slot
   always_comb begin
      if (tok_ff.valid && (phase_ff == PH_READ) && (tok_ff.op != OP_SIFT)) begin
         addr_a = AW'(tok_ff.off);
      end else if (kreq_prev.valid) begin
         addr_a = AW'({kreq_prev.off, 1'b0});
      end else begin
         addr_a = '0;
      end
      if (kreq_prev.valid) begin
         addr_b = AW'({kreq_prev.off, 1'b1});
      end else begin
         addr_b = AW'(ctrl.rd_off);
      end
   end

   // child read request to the next level during a sift read phase
   always_comb begin
      kreq_next.valid = tok_ff.valid && (phase_ff == PH_READ) && (tok_ff.op == OP_SIFT);
      kreq_next.off   = tok_ff.off;
   end

   // decide: slot write and token handed on
   always_comb begin
      lidx    = IW'(LBASE) + IW'({tok_ff.off, 1'b0});
      ridx    = lidx + IW'(1);
      cnt_ext = IW'(tok_ff.cnt);
      pick_l  = 1'b0;
      pick_r  = 1'b0;
      best_e  = tok_ff.entry;
      wr_en   = 1'b0;
      wr_addr = AW'(tok_ff.off);
      wr_data = tok_ff.entry;
      fwd     = tok_ff;
      fwd.valid = 1'b0;
      case (tok_ff.op)
         OP_INSERT, OP_SHIFT: begin
            fwd.off  = OW'({tok_ff.off, tok_ff.path[CW-1]});
            fwd.path = tok_ff.path << 1;
            if (tok_ff.dest_lvl == LW'(LEVEL)) begin
               wr_en = exec;
            end else begin
               fwd.valid = exec;
               // once a slot is taken, each lower slot on the path moves down
               if ((tok_ff.op == OP_SHIFT) || ahead(tok_ff.entry, rd_a)) begin
                  wr_en     = exec;
                  fwd.entry = rd_a;
                  fwd.op    = OP_SHIFT;
               end
            end
         end
         OP_SIFT: begin
            pick_l = (lidx < cnt_ext) && ahead(kid_in.a, tok_ff.entry);
            best_e = pick_l ? kid_in.a : tok_ff.entry;
            pick_r = (ridx < cnt_ext) && ahead(kid_in.b, best_e);
            wr_en  = exec;
            if (pick_r) begin
               wr_data   = kid_in.b;
               fwd.valid = exec;
               fwd.off   = OW'({tok_ff.off, 1'b1});
            end else if (pick_l) begin
               wr_data   = kid_in.a;
               fwd.valid = exec;
               fwd.off   = OW'({tok_ff.off, 1'b0});
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      // root update from the sequencer
      if ((LEVEL == 0) && ctrl.root_we) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = ctrl.root_data;
      end
   end

   assign tok_next = fwd;
   assign done     = exec && !fwd.valid;

   // token and phase next values
   always_comb begin
      tok_in = tok_ff;
      if (tok_prev.valid) begin
         tok_in = tok_prev;
      end else if (exec) begin
         tok_in.valid = 1'b0;
      end
   end

   always_comb begin
      if (tok_prev.valid) begin
         phase_in = PH_READ;
      end else if (tok_ff.valid && (phase_ff == PH_READ)) begin
         phase_in = PH_EXEC;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         phase_ff     <= PH_READ;
      end else begin
         tok_ff   <= tok_in;
         phase_ff <= phase_in;
      end
   end

   // slot storage of this level
   ppsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SIZE)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   assign rd_a = task_entry_type'(ram_a);
   assign rd_b = task_entry_type'(ram_b);

endmodule

/* design/preemptive_priority_scheduler_core.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core - tick-driven preemptive task scheduler
// Max-priority heap of ready tasks kept as a chain of level cells.
//
//   channel   ports                        transfer
//   -------   --------------------------   ------------------------------
//   request   start, busy, req_*           rising edge with start & !busy
//   response  rsp_strobe, rsp_*            every cycle rsp_strobe is high
//
// Every request gives one response, registered in the cycle after it for an
// arrival or an empty-queue tick; other ticks set it in the tick state. An
// arrival holds busy while its token walks to the new slot's level; a full
// queue or an empty-queue tick has no busy time. Other ticks hold busy in the
// tick state and, when a finishing task leaves others, the sift-down walk.
// Each level cell reads its RAM in one phase and decides in the next.
// Synchronous reset empties the queue and clears the tick count; slot
// contents need no clearing. The response side cannot stall.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
   parameter int QUEUE_DEPTH = ppsc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_burst_length,
   input  logic [7:0]  req_task_priority,
   output logic        rsp_strobe,
   output logic        rsp_status,
   output logic        rsp_ran_valid,
   output logic [7:0]  rsp_ran_id,
   output logic        rsp_finished,
   output logic [15:0] rsp_start_time,
   output logic [15:0] rsp_turnaround,
   output logic [15:0] rsp_wait_time
);
   import ppsc_pkg::*;

   localparam int OW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NL = CW;
   localparam int LW = $clog2(NL);

   typedef struct packed {
      logic           valid;
      heap_op_type    op;
      task_entry_type entry;
      logic [OW-1:0]  off;
      logic [CW-1:0]  cnt;
      logic [CW-1:0]  path;
      logic [LW-1:0]  dest_lvl;
   } token_type;

   typedef struct packed {
      logic          valid;
      logic [OW-1:0] off;
   } child_req_type;

   typedef struct packed {
      task_entry_type a;
      task_entry_type b;
   } child_data_type;

   typedef struct packed {
      logic [OW-1:0]  rd_off;
      logic           root_we;
      task_entry_type root_data;
   } ctrl_type;

   // position of the highest set bit
   function automatic logic [LW-1:0] msb_pos(logic [CW-1:0] v);
      logic [LW-1:0] pos;
      pos = '0;
      for (int j = 0; j < CW; j++) begin
         if (v[j]) begin
            pos = LW'(j);
         end
      end
      return pos;
   endfunction

   sched_state_type state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [15:0]     tick_ff, tick_in;
   logic [LW-1:0]   lvl_ff, lvl_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic        rsp_status_ff, rsp_status_in;
   logic        rsp_ran_valid_ff, rsp_ran_valid_in;
   logic [7:0]  rsp_ran_id_ff, rsp_ran_id_in;
   logic        rsp_finished_ff, rsp_finished_in;
   logic [15:0] rsp_start_ff, rsp_start_in;
   logic [15:0] rsp_turn_ff, rsp_turn_in;
   logic [15:0] rsp_wait_ff, rsp_wait_in;

   token_type      tok_chain  [NL+1];
   child_req_type  kreq_chain [NL+1];
   child_data_type kid_vec    [NL];
   task_entry_type rd_a_vec   [NL];
   task_entry_type rd_b_vec   [NL];
   logic [NL-1:0]  done_vec;
   token_type      tok_inject;
   ctrl_type       ctrl;

   logic           accept;
   logic           walk_done;
   logic           queue_full;
   task_entry_type new_entry;
   logic [7:0]     burst_eff;
   logic [CW-1:0]  ins_n, ins_path, lst_masked;
   logic [LW-1:0]  ins_lvl, lst_lvl;
   task_entry_type root_e, root_upd, last_e;
   logic [15:0]    turn, wait_t;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign walk_done  = (|done_vec) || tok_chain[NL].valid;
   assign queue_full = (count_ff >= CW'(QUEUE_DEPTH));

   // arrival entry and the path to its slot
   always_comb begin
      burst_eff              = (req_burst_length == 8'd0) ? 8'd1 : req_burst_length;
      new_entry.id           = req_task_id;
      new_entry.burst        = burst_eff;
      new_entry.prio         = req_task_priority;
      new_entry.remaining    = burst_eff;
      new_entry.arrival_tick = tick_ff;
      new_entry.start_tick   = '0;
      ins_n    = count_ff + CW'(1);
      ins_lvl  = msb_pos(ins_n);
      ins_path = ins_n << (CW - int'(ins_lvl));
   end

   // location of the last occupied slot
   always_comb begin
      lst_lvl             = msb_pos(count_ff);
      lst_masked          = count_ff;
      lst_masked[lst_lvl] = 1'b0;
   end

   // head task run for one tick
   always_comb begin
      root_e             = rd_a_vec[0];
      last_e             = rd_b_vec[lvl_ff];
      root_upd           = root_e;
      root_upd.remaining = root_e.remaining - 8'd1;
      if (root_e.remaining == root_e.burst) begin
         root_upd.start_tick = tick_ff;
      end
      turn   = tick_ff + 16'd1 - root_e.arrival_tick;
      wait_t = turn - {8'd0, root_e.burst};
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode && (count_ff != '0)) begin
               state_in = ST_TICK;
            end else if (accept && !req_mode && !queue_full) begin
               state_in = ST_WALK;
            end
         end
         ST_TICK: begin
            if ((root_upd.remaining == 8'd0) && (count_ff != CW'(1))) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs: counters, tokens, root write, response
   always_comb begin
      count_in          = count_ff;
      tick_in           = tick_ff;
      lvl_in            = lvl_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = 1'b0;
      rsp_ran_valid_in  = 1'b0;
      rsp_ran_id_in     = '0;
      rsp_finished_in   = 1'b0;
      rsp_start_in      = '0;
      rsp_turn_in       = '0;
      rsp_wait_in       = '0;
      tok_inject        = '0;
      ctrl.rd_off       = OW'(lst_masked);
      ctrl.root_we      = 1'b0;
      ctrl.root_data    = root_upd;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_mode) begin
                  rsp_strobe_in = 1'b1;
                  if (queue_full) begin
                     rsp_status_in = 1'b1;
                  end else begin
                     tok_inject.valid    = 1'b1;
                     tok_inject.op       = OP_INSERT;
                     tok_inject.entry    = new_entry;
                     tok_inject.cnt      = ins_n;
                     tok_inject.path     = ins_path;
                     tok_inject.dest_lvl = ins_lvl;
                     count_in            = ins_n;
                  end
               end else if (count_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  tick_in       = tick_ff + 16'd1;
               end else begin
                  lvl_in = lst_lvl;
               end
            end
         end
         ST_TICK: begin
            rsp_strobe_in    = 1'b1;
            rsp_ran_valid_in = 1'b1;
            rsp_ran_id_in    = root_e.id;
            tick_in          = tick_ff + 16'd1;
            if (root_upd.remaining != 8'd0) begin
               ctrl.root_we = 1'b1;
            end else begin
               rsp_finished_in = 1'b1;
               rsp_start_in    = root_upd.start_tick;
               rsp_turn_in     = turn;
               rsp_wait_in     = wait_t;
               count_in        = count_ff - CW'(1);
               if (count_ff != CW'(1)) begin
                  tok_inject.valid = 1'b1;
                  tok_inject.op    = OP_SIFT;
                  tok_inject.entry = last_e;
                  tok_inject.cnt   = count_ff - CW'(1);
               end
            end
         end
         ST_WALK: begin
            count_in = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         tick_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // response payload and last-slot level
   always_ff @(posedge clock) begin
      lvl_ff           <= lvl_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_ran_valid_ff <= rsp_ran_valid_in;
      rsp_ran_id_ff    <= rsp_ran_id_in;
      rsp_finished_ff  <= rsp_finished_in;
      rsp_start_ff     <= rsp_start_in;
      rsp_turn_ff      <= rsp_turn_in;
      rsp_wait_ff      <= rsp_wait_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_ran_valid  = rsp_ran_valid_ff;
   assign rsp_ran_id     = rsp_ran_id_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_start_time = rsp_start_ff;
   assign rsp_turnaround = rsp_turn_ff;
   assign rsp_wait_time  = rsp_wait_ff;

   // chain of level cells
   assign tok_chain[0]  = tok_inject;
   assign kreq_chain[0] = '0;

   for (genvar k = 0; k < NL; k++) begin : g_level
      if (k < NL - 1) begin : g_kid
         assign kid_vec[k] = '{a: rd_a_vec[k+1], b: rd_b_vec[k+1]};
      end else begin : g_leaf
         assign kid_vec[k] = '0;
      end

      ppsc_cell #(
         .DEPTH (QUEUE_DEPTH),
         .LEVEL (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_prev  (tok_chain[k]),
         .tok_next  (tok_chain[k+1]),
         .kreq_prev (kreq_chain[k]),
         .kreq_next (kreq_chain[k+1]),
         .kid_in    (kid_vec[k]),
         .rd_a      (rd_a_vec[k]),
         .rd_b      (rd_b_vec[k]),
         .ctrl      (ctrl),
         .done      (done_vec[k])
      );
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for preemptive_priority_scheduler_core
// Sends arrival and tick requests over the start/busy channel and keeps a
// shadow heap of ready tasks and its own tick count. The expected response
// for every accepted request is queued, and each rsp_strobe transfer is
// compared field by field with the oldest one. Directed tests cover the
// empty queue, preemption, priority ties and the full queue. Random
// traffic follows, with several sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
   import ppsc_pkg::*;

   localparam int QDEPTH = QUEUE_DEPTH_DEF;

   // request mode codes
   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // one expected response
   typedef struct packed {
      logic        status;
      logic        ran_valid;
      logic [7:0]  ran_id;
      logic        finished;
      logic [15:0] start_time;
      logic [15:0] turnaround;
      logic [15:0] wait_time;
   } sched_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_TICK;
   logic [7:0]  req_task_id = 8'd0;
   logic [7:0]  req_burst_length = 8'd0;
   logic [7:0]  req_task_priority = 8'd0;
   logic        rsp_strobe;
   logic        rsp_status;
   logic        rsp_ran_valid;
   logic [7:0]  rsp_ran_id;
   logic        rsp_finished;
   logic [15:0] rsp_start_time;
   logic [15:0] rsp_turnaround;
   logic [15:0] rsp_wait_time;

   // shadow scheduler state
   task_entry_type sched_heap [QDEPTH];
   int unsigned    queued = 0;
   logic [15:0]    now_tick = 16'd0;

   sched_outcome_type outcome_q[$];
   int unsigned       mismatch_count = 0;
   int unsigned       idle_pct = 0;

   preemptive_priority_scheduler_core #(
      .QUEUE_DEPTH(QDEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_task_id(req_task_id),
      .req_burst_length(req_burst_length),
      .req_task_priority(req_task_priority),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_ran_valid(rsp_ran_valid),
      .rsp_ran_id(rsp_ran_id),
      .rsp_finished(rsp_finished),
      .rsp_start_time(rsp_start_time),
      .rsp_turnaround(rsp_turnaround),
      .rsp_wait_time(rsp_wait_time)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // shadow heap
   // ------------------------------------------------------------------

   // higher priority is served first, lower id breaks a tie
   function automatic bit runs_first(task_entry_type a, task_entry_type b);
      return (a.prio > b.prio) || (a.prio == b.prio && a.id < b.id);
   endfunction

   function automatic void heap_push(task_entry_type e);
      int unsigned    cur;
      int unsigned    par;
      task_entry_type t;
      cur = queued;
      sched_heap[cur] = e;
      queued++;
      while (cur > 0) begin
         par = (cur - 1) / 2;
         if (!runs_first(sched_heap[cur], sched_heap[par])) break;
         t = sched_heap[cur];
         sched_heap[cur] = sched_heap[par];
         sched_heap[par] = t;
         cur = par;
      end
   endfunction

   function automatic void heap_pop_head();
      int unsigned    cur;
      int unsigned    best;
      int unsigned    l;
      int unsigned    r;
      task_entry_type t;
      if (queued == 0) return;
      queued--;
      if (queued == 0) return;
      sched_heap[0] = sched_heap[queued];
      best = 0;
      // sift the moved entry down until both children rank below it
      do begin
         cur = best;
         l = 2 * cur + 1;
         r = l + 1;
         if (l < queued && runs_first(sched_heap[l], sched_heap[best])) best = l;
         if (r < queued && runs_first(sched_heap[r], sched_heap[best])) best = r;
         if (best != cur) begin
            t = sched_heap[cur];
            sched_heap[cur] = sched_heap[best];
            sched_heap[best] = t;
         end
      end while (best != cur);
   endfunction

   // apply one request to the shadow state and return its response
   function automatic sched_outcome_type schedule_step(logic mode, logic [7:0] id,
                                                       logic [7:0] burst, logic [7:0] prio);
      sched_outcome_type o;
      task_entry_type    e;
      logic [7:0]        len;
      o = '0;
      if (mode == MODE_ARRIVAL) begin
         // zero burst counts as one tick of work
         len = (burst == 8'd0) ? 8'd1 : burst;
         if (queued >= QDEPTH) begin
            o.status = 1'b1;
         end else begin
            e = '0;
            e.id = id;
            e.burst = len;
            e.prio = prio;
            e.remaining = len;
            e.arrival_tick = now_tick;
            heap_push(e);
         end
      end else begin
         if (queued != 0) begin
            e = sched_heap[0];
            if (e.remaining == e.burst) e.start_tick = now_tick;
            e.remaining = e.remaining - 8'd1;
            sched_heap[0] = e;
            o.ran_valid = 1'b1;
            o.ran_id = e.id;
            if (e.remaining == 8'd0) begin
               o.finished = 1'b1;
               o.start_time = e.start_tick;
               o.turnaround = now_tick + 16'd1 - e.arrival_tick;
               o.wait_time = o.turnaround - {8'd0, e.burst};
               heap_pop_head();
            end
         end
         now_tick = now_tick + 16'd1;
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // one request transfer; drives start and returns once busy reads low after an edge
   task automatic send_item(input logic mode, input logic [7:0] id,
                            input logic [7:0] burst, input logic [7:0] prio);
      // random sender gap ahead of the request
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_task_id <= id;
      req_burst_length <= burst;
      req_task_priority <= prio;
      @(posedge clock);
      while (busy) @(posedge clock);
      outcome_q.push_back(schedule_step(mode, id, burst, prio));
   endtask

   // tick with junk in the unused fields
   task automatic send_tick();
      send_item(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   // hold requests off until every response is back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      sched_outcome_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (outcome_q.size() == 0) begin
            mismatch_count++;
            $error("response transfer with no request outstanding");
         end else begin
            want = outcome_q.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("ran_valid", 16'(want.ran_valid), 16'(rsp_ran_valid));
            check_field("ran_id", 16'(want.ran_id), 16'(rsp_ran_id));
            check_field("finished", 16'(want.finished), 16'(rsp_finished));
            check_field("start_time", want.start_time, rsp_start_time);
            check_field("turnaround", want.turnaround, rsp_turnaround);
            check_field("wait_time", want.wait_time, rsp_wait_time);
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // tick on an empty queue: nothing runs, clock still moves
   task automatic test_empty_tick();
      send_tick();
   endtask

   // a higher priority arrival takes over from a running task
   task automatic test_preemption();
      send_item(MODE_ARRIVAL, 8'd1, 8'd3, 8'd4);
      send_tick();
      send_item(MODE_ARRIVAL, 8'd2, 8'd1, 8'd9);
      repeat (3) send_tick();
   endtask

   // equal priority: lower id first, and a repeated id
   task automatic test_priority_ties();
      send_item(MODE_ARRIVAL, 8'd9, 8'd1, 8'd7);
      send_item(MODE_ARRIVAL, 8'd3, 8'd2, 8'd7);
      send_item(MODE_ARRIVAL, 8'd3, 8'd1, 8'd7);
      repeat (4) send_tick();
   endtask

   // fill every slot with field extremes, then one rejected arrival
   task automatic test_queue_full();
      logic [7:0] id;
      logic [7:0] burst;
      logic [7:0] prio;
      for (int i = 0; i < QDEPTH; i++) begin
         id = (i == 0) ? 8'd0 : (i == QDEPTH - 1) ? 8'd255 : 8'($urandom_range(255));
         burst = (i == 1) ? 8'd0 : (i == 2) ? 8'd255 : 8'($urandom_range(3, 1));
         prio = (i == 3) ? 8'd0 : (i == 4) ? 8'd255 : 8'($urandom_range(255));
         send_item(MODE_ARRIVAL, id, burst, prio);
      end
      send_item(MODE_ARRIVAL, 8'd77, 8'd5, 8'd255);
   endtask

   // random arrivals and ticks in phases of differing load and idling
   task automatic test_random_traffic();
      int unsigned idle_mix[5];
      int unsigned arrival_mix[5];
      int unsigned pick;
      logic [7:0]  id;
      logic [7:0]  burst;
      logic [7:0]  prio;
      idle_mix = '{0, 54, 17, 0, 54};
      arrival_mix = '{35, 30, 60, 25, 40};
      for (int ph = 0; ph < 5; ph++) begin
         idle_pct = idle_mix[ph];
         for (int n = 0; n < 270; n++) begin
            if ($urandom_range(99) < arrival_mix[ph]) begin
               // mostly short jobs, a few long ones
               pick = $urandom_range(99);
               if (pick < 70) burst = 8'($urandom_range(3, 1));
               else if (pick < 90) burst = 8'($urandom_range(12, 4));
               else if (pick < 96) burst = 8'd0;
               else burst = 8'($urandom_range(255));
               // narrow ranges half the time so ties happen
               id = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
               prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
               send_item(MODE_ARRIVAL, id, burst, prio);
            end else begin
               send_tick();
            end
         end
         wait_drained();
      end
      idle_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_tick();
      test_preemption();
      test_priority_ties();
      test_queue_full();
      test_random_traffic();
      wait_drained();
      repeat (24) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #25000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
design/ppsc_pkg.sv
design/ppsc_ram.sv
design/ppsc_cell.sv
design/preemptive_priority_scheduler_core.sv
verif/tb_top.sv
